>>> src/bsalu_pkg.sv
// Shared types and codes for the 16-bit bit-slice ALU.
`default_nettype none

package bsalu_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned IDX_W  = 4;

  // Source pair codes, instruction bits 2..0.
  localparam logic [2:0] SRC_AQ = 3'd0;
  localparam logic [2:0] SRC_AB = 3'd1;
  localparam logic [2:0] SRC_ZQ = 3'd2;
  localparam logic [2:0] SRC_ZB = 3'd3;
  localparam logic [2:0] SRC_ZA = 3'd4;
  localparam logic [2:0] SRC_DA = 3'd5;
  localparam logic [2:0] SRC_DQ = 3'd6;
  localparam logic [2:0] SRC_DZ = 3'd7;

  // Function codes, instruction bits 5..3.
  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_SUBR = 3'd1;
  localparam logic [2:0] FN_SUBS = 3'd2;
  localparam logic [2:0] FN_OR   = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_NOTRS = 3'd5;
  localparam logic [2:0] FN_XOR  = 3'd6;
  localparam logic [2:0] FN_XNOR = 3'd7;

  // Destination codes.
  localparam logic [2:0] DST_QREG = 3'd0;
  localparam logic [2:0] DST_NOP  = 3'd1;
  localparam logic [2:0] DST_RAMA = 3'd2;
  localparam logic [2:0] DST_RAMF = 3'd3;
  localparam logic [2:0] DST_RAMQD = 3'd4;
  localparam logic [2:0] DST_RAMD = 3'd5;
  localparam logic [2:0] DST_RAMQU = 3'd6;
  localparam logic [2:0] DST_RAMU = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]  a_index;
    logic [IDX_W-1:0]  b_index;
    logic [5:0]        alu_instruction;
    logic [2:0]        destination_code;
    logic              carry_in;
    logic [WORD_W-1:0] direct_data;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] alu_result;
    logic [WORD_W-1:0] y_output;
  } out_item_t;

  // Write-back request from the ALU datapath.
  typedef struct packed {
    logic              rf_we;
    logic              q_we;
    logic [WORD_W-1:0] rf_data;
    logic [WORD_W-1:0] q_data;
  } wb_t;

endpackage

`default_nettype wire

>>> src/bit_slice_alu_16bit.sv
// Top level of the 16-bit bit-slice ALU: pipeline control, Q register and result register.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   bsalu_pkg::in_item_t (one microinstruction)
//   out_      output     out_valid/out_stall bsalu_pkg::out_item_t (F and Y)
//
// One microinstruction is accepted every clock while in_stall is low; each passes
// through the execute stage into the result register. The register file read is
// registered in the synchronous memory, then the ALU and write-back settle in the execute stage.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes Q and marks every
// register file entry as reading zero, so no clearing pass is needed.
// out_stall holds the result register; the execute stage then holds too and
// in_stall rises only while that stage is occupied and cannot move on.
`default_nettype none

module bit_slice_alu_16bit #(
  parameter int unsigned NUM_REGS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bsalu_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bsalu_pkg::out_item_t      out_data
);

  localparam int unsigned AW = $clog2(NUM_REGS);

  // Execute stage: the accepted microinstruction waits here while its
  // operands come out of the register file memory.
  logic                         s1_valid_r;
  bsalu_pkg::in_item_t          s1_item_r;
  logic [bsalu_pkg::WORD_W-1:0] q_r;
  logic [bsalu_pkg::WORD_W-1:0] q_nxt;
  logic                         out_valid_r;
  bsalu_pkg::out_item_t         out_data_r;

  logic                         accept;
  logic                         advance;
  logic [bsalu_pkg::WORD_W-1:0] a_val;
  logic [bsalu_pkg::WORD_W-1:0] b_val;
  bsalu_pkg::out_item_t         alu_res;
  bsalu_pkg::wb_t               wb;
  logic                         rf_we;

  // The execute stage commits (register file, Q, result) only when the
  // result register can take its result this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign rf_we    = advance && wb.rf_we;

  // The memory read is issued on the transfer edge. A write by the item
  // ahead on that same edge is forwarded inside the register file.
  bsalu_rf #(
    .NUM_REGS (NUM_REGS)
  ) u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (in_data.a_index[AW-1:0]),
    .rd_addr_b (in_data.b_index[AW-1:0]),
    .wr_en     (rf_we),
    .wr_addr   (s1_item_r.b_index[AW-1:0]),
    .wr_data   (wb.rf_data),
    .rd_data_a (a_val),
    .rd_data_b (b_val)
  );

  bsalu_alu u_alu (
    .a_val  (a_val),
    .b_val  (b_val),
    .q_val  (q_r),
    .item   (s1_item_r),
    .result (alu_res),
    .wb     (wb)
  );

  // Q lives in flip-flops and is updated in the execute stage, so the next
  // item sees the new value without any forwarding.
  assign q_nxt = (advance && wb.q_we) ? wb.q_data : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      q_r         <= '0;
    end else begin
      q_r <= q_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && in_stall) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("execute stage lost or changed a stalled item");
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_valid_r && out_data_r == $past(alu_res)))
    else $error("advanced item did not reach the result register");
  a_q_down_msb: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.destination_code == bsalu_pkg::DST_RAMQD) |=> !q_r[bsalu_pkg::WORD_W-1])
    else $error("Q down shift did not fill the MSB with zero");
  a_q_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(q_r))
    else $error("Q changed without an executing item");
`endif

endmodule

`default_nettype wire

>>> src/bsalu_rf.sv
// Register file memory with registered reads, entry valid bits and write forwarding.
`default_nettype none

module bsalu_rf #(
  parameter int unsigned NUM_REGS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(NUM_REGS)-1:0]       rd_addr_a,
  input  wire logic [$clog2(NUM_REGS)-1:0]       rd_addr_b,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(NUM_REGS)-1:0]       wr_addr,
  input  wire logic [bsalu_pkg::WORD_W-1:0]      wr_data,
  output logic      [bsalu_pkg::WORD_W-1:0]      rd_data_a,
  output logic      [bsalu_pkg::WORD_W-1:0]      rd_data_b
);

  localparam int unsigned AW = $clog2(NUM_REGS);

  logic [bsalu_pkg::WORD_W-1:0] mem [NUM_REGS];
  logic [bsalu_pkg::WORD_W-1:0] rd_a_r;
  logic [bsalu_pkg::WORD_W-1:0] rd_b_r;
  logic [AW-1:0]                raddr_a_r;
  logic [AW-1:0]                raddr_b_r;
  logic                         fwd_en_r;
  logic [AW-1:0]                fwd_addr_r;
  logic [bsalu_pkg::WORD_W-1:0] fwd_data_r;
  logic [NUM_REGS-1:0]          vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r     <= mem[rd_addr_a];
      rd_b_r     <= mem[rd_addr_b];
      raddr_a_r  <= rd_addr_a;
      raddr_b_r  <= rd_addr_b;
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // A write landing on the read edge is missed by the array read and is
  // forwarded instead; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      fwd_en_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_en_r <= wr_en;
      end
    end
  end

  always_comb begin
    if (fwd_en_r && (fwd_addr_r == raddr_a_r)) begin
      rd_data_a = fwd_data_r;
    end else if (vld_r[raddr_a_r]) begin
      rd_data_a = rd_a_r;
    end else begin
      rd_data_a = '0;
    end
    if (fwd_en_r && (fwd_addr_r == raddr_b_r)) begin
      rd_data_b = fwd_data_r;
    end else if (vld_r[raddr_b_r]) begin
      rd_data_b = rd_b_r;
    end else begin
      rd_data_b = '0;
    end
  end

`ifndef SYNTHESIS
  a_rf_reset_clears: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("register file valid bits not cleared by reset");
  a_rf_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(wr_addr)])
    else $error("written entry not marked valid");
  a_rf_fwd_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |=> (fwd_en_r && fwd_data_r == $past(wr_data)))
    else $error("forwarding register missed a same-edge write");
`endif

endmodule

`default_nettype wire

>>> src/bsalu_alu.sv
// Source selection, ALU function and destination shifter of the bit-slice datapath.
`default_nettype none

module bsalu_alu (
  input  wire logic [bsalu_pkg::WORD_W-1:0] a_val,
  input  wire logic [bsalu_pkg::WORD_W-1:0] b_val,
  input  wire logic [bsalu_pkg::WORD_W-1:0] q_val,
  input  wire bsalu_pkg::in_item_t          item,
  output bsalu_pkg::out_item_t              result,
  output bsalu_pkg::wb_t                    wb
);

  logic [bsalu_pkg::WORD_W-1:0] r_op;
  logic [bsalu_pkg::WORD_W-1:0] s_op;
  logic [bsalu_pkg::WORD_W-1:0] f_val;
  logic [bsalu_pkg::WORD_W-1:0] cin_ext;
  logic [2:0]                   src_sel;
  logic [2:0]                   fn_sel;

  assign src_sel = item.alu_instruction[2:0];
  assign fn_sel  = item.alu_instruction[5:3];
  assign cin_ext = {{(bsalu_pkg::WORD_W-1){1'b0}}, item.carry_in};

  always_comb begin
    unique case (src_sel)
      bsalu_pkg::SRC_AQ: begin r_op = a_val;            s_op = q_val; end
      bsalu_pkg::SRC_AB: begin r_op = a_val;            s_op = b_val; end
      bsalu_pkg::SRC_ZQ: begin r_op = '0;               s_op = q_val; end
      bsalu_pkg::SRC_ZB: begin r_op = '0;               s_op = b_val; end
      bsalu_pkg::SRC_ZA: begin r_op = '0;               s_op = a_val; end
      bsalu_pkg::SRC_DA: begin r_op = item.direct_data; s_op = a_val; end
      bsalu_pkg::SRC_DQ: begin r_op = item.direct_data; s_op = q_val; end
      default:           begin r_op = item.direct_data; s_op = '0;    end
    endcase
  end

  // Carries beyond bit 15 are dropped.
  always_comb begin
    unique case (fn_sel)
      bsalu_pkg::FN_ADD:   f_val = r_op + s_op + cin_ext;
      bsalu_pkg::FN_SUBR:  f_val = ~r_op + s_op + cin_ext;
      bsalu_pkg::FN_SUBS:  f_val = r_op + ~s_op + cin_ext;
      bsalu_pkg::FN_OR:    f_val = r_op | s_op;
      bsalu_pkg::FN_AND:   f_val = r_op & s_op;
      bsalu_pkg::FN_NOTRS: f_val = ~r_op & s_op;
      bsalu_pkg::FN_XOR:   f_val = r_op ^ s_op;
      default:             f_val = ~(r_op ^ s_op);
    endcase
  end

  always_comb begin
    result.alu_result = f_val;
    result.y_output   = f_val;
    wb.rf_we   = 1'b1;
    wb.q_we    = 1'b0;
    wb.rf_data = f_val;
    wb.q_data  = f_val;
    unique case (item.destination_code)
      bsalu_pkg::DST_QREG: begin
        wb.rf_we = 1'b0;
        wb.q_we  = 1'b1;
      end
      bsalu_pkg::DST_NOP: begin
        wb.rf_we = 1'b0;
      end
      bsalu_pkg::DST_RAMA: begin
        result.y_output = a_val;
      end
      bsalu_pkg::DST_RAMF: begin
        wb.rf_data = f_val;
      end
      bsalu_pkg::DST_RAMQD: begin
        wb.q_we    = 1'b1;
        wb.rf_data = {1'b1, f_val[bsalu_pkg::WORD_W-1:1]};
        wb.q_data  = {1'b0, q_val[bsalu_pkg::WORD_W-1:1]};
      end
      bsalu_pkg::DST_RAMD: begin
        wb.rf_data = {1'b1, f_val[bsalu_pkg::WORD_W-1:1]};
      end
      bsalu_pkg::DST_RAMQU: begin
        wb.q_we    = 1'b1;
        wb.rf_data = {f_val[bsalu_pkg::WORD_W-2:0], 1'b0};
        wb.q_data  = {q_val[bsalu_pkg::WORD_W-2:0], 1'b0};
      end
      default: begin
        wb.rf_data = {f_val[bsalu_pkg::WORD_W-2:0], 1'b0};
      end
    endcase
  end

endmodule

`default_nettype wire
